// ===== design/zbpw_pkg.sv =====
// Shared types and constants for the depth-buffered pixel writer.
package zbpw_pkg;

    localparam int DIM_W      = 13;
    localparam int FRAME_W    = 9;
    localparam int COORD_W    = 16;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int DEFAULT_MAX_WIDTH  = 256;
    localparam int DEFAULT_MAX_HEIGHT = 256;

    localparam logic signed [DEPTH_W-1:0] RESET_DEPTH = -16'sd100;

    typedef enum logic [1:0] {
        FUNC_DRAW  = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_CLEAR_DEPTH  = 2'd2,
        CFG_CLEAR_COLOR  = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic sweep_start;
        logic lookup;
        logic clr_rd;
        logic clr_wr;
        logic init_wr;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t in_func;
        logic  clear_empty;
        logic  sweep_last;
        logic  init_last;
        logic  out_free;
    } dp_status_t;

endpackage

// ===== design/zbpw_ctrl.sv =====
// Command sequencer: init sweep, lookup, clear sweep and result hand-off.
module zbpw_ctrl
    import zbpw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (status.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (status.in_func)
                        FUNC_DRAW, FUNC_READ:
                        begin
                            state_next = ST_LOOKUP;
                        end
                        FUNC_CLEAR:
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next = status.clear_empty ? ST_FINISH : ST_CLR_RD;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_FINISH;
            end
            ST_CLR_RD:
            begin
                cmd.clr_rd = 1'b1;
                state_next = ST_CLR_WR;
            end
            ST_CLR_WR:
            begin
                cmd.clr_wr = 1'b1;
                state_next = status.sweep_last ? ST_FINISH : ST_CLR_RD;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ===== design/zbpw_datapath.sv =====
// Config registers, command latch, pixel stores, sweep counters and output register.
module zbpw_datapath
    import zbpw_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 cmd,
    output dp_status_t                status,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                func,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [DEPTH_W-1:0] point_depth,
    input  logic [COLOR_W-1:0]        point_color,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      written,
    output logic [COLOR_W-1:0]        read_color,
    output logic signed [DEPTH_W-1:0] read_depth
);

    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // configuration
    logic [FRAME_W-1:0]        frame_width_reg;
    logic [FRAME_W-1:0]        frame_height_reg;
    logic signed [DEPTH_W-1:0] clear_depth_reg;
    logic [COLOR_W-1:0]        clear_color_reg;

    logic [DIM_W-1:0] active_w;
    logic [DIM_W-1:0] active_h;
    logic             in_frame;

    // latched command
    func_t                     cmd_func_reg;
    logic                      cmd_in_frame_reg;
    logic [AW-1:0]             cmd_addr_reg;
    logic signed [DEPTH_W-1:0] cmd_depth_reg;
    logic [COLOR_W-1:0]        cmd_color_reg;

    // sweeps
    logic [XW-1:0] cx_reg;
    logic [YW-1:0] cy_reg;
    logic [AW-1:0] init_cnt_reg;
    logic [AW-1:0] sweep_addr;
    logic          cx_last;
    logic          cy_last;

    // stores
    logic signed [DEPTH_W-1:0] depth_mem [MEM_DEPTH];
    logic [COLOR_W-1:0]        color_mem [MEM_DEPTH];
    logic signed [DEPTH_W-1:0] rd_depth_reg;
    logic [COLOR_W-1:0]        rd_color_reg;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic signed [DEPTH_W-1:0] wr_depth;
    logic [COLOR_W-1:0]        wr_color;
    logic                      draw_pass;

    // result
    logic                      out_valid_reg;
    logic                      written_reg;
    logic [COLOR_W-1:0]        read_color_reg;
    logic signed [DEPTH_W-1:0] read_depth_reg;
    logic                      out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_W'(256);
            frame_height_reg <= FRAME_W'(256);
            clear_depth_reg  <= RESET_DEPTH;
            clear_color_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_W-1:0];
                CFG_CLEAR_DEPTH:  clear_depth_reg  <= $signed(cfg_data[DEPTH_W-1:0]);
                CFG_CLEAR_COLOR:  clear_color_reg  <= cfg_data[COLOR_W-1:0];
                default:          clear_color_reg  <= clear_color_reg;
            endcase
        end
    end

    // widths and heights above the store size clamp to it
    always_comb
    begin
        active_w = (DIM_W'(frame_width_reg) > DIM_W'(MAX_WIDTH))
                   ? DIM_W'(MAX_WIDTH) : DIM_W'(frame_width_reg);
        active_h = (DIM_W'(frame_height_reg) > DIM_W'(MAX_HEIGHT))
                   ? DIM_W'(MAX_HEIGHT) : DIM_W'(frame_height_reg);
        in_frame = !pos_x[COORD_W-1] && !pos_y[COORD_W-1]
                   && ($unsigned(pos_x) < COORD_W'(active_w))
                   && ($unsigned(pos_y) < COORD_W'(active_h));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_func_reg     <= func_t'(func);
            cmd_in_frame_reg <= in_frame;
            cmd_addr_reg     <= AW'(pos_y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(pos_x[XW-1:0]);
            cmd_depth_reg    <= point_depth;
            cmd_color_reg    <= point_color;
        end
    end

    always_comb
    begin
        cx_last    = (DIM_W'(cx_reg) == active_w - DIM_W'(1));
        cy_last    = (DIM_W'(cy_reg) == active_h - DIM_W'(1));
        sweep_addr = AW'(cy_reg) * AW'(MAX_WIDTH) + AW'(cx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg       <= '0;
            cy_reg       <= '0;
            init_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.init_wr)
            begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end
            if (cmd.sweep_start)
            begin
                cx_reg <= '0;
                cy_reg <= '0;
            end
            else if (cmd.clr_wr)
            begin
                if (cx_last)
                begin
                    cx_reg <= '0;
                    cy_reg <= cy_reg + YW'(1);
                end
                else
                begin
                    cx_reg <= cx_reg + XW'(1);
                end
            end
        end
    end

    assign draw_pass = (cmd_func_reg == FUNC_DRAW) && cmd_in_frame_reg
                       && (cmd_depth_reg > rd_depth_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        rd_en    = cmd.lookup || cmd.clr_rd;
        rd_addr  = cmd.clr_rd ? sweep_addr : cmd_addr_reg;
        wr_en    = 1'b0;
        wr_addr  = cmd_addr_reg;
        wr_depth = cmd_depth_reg;
        wr_color = cmd_color_reg;
        priority if (cmd.init_wr)
        begin
            wr_en    = 1'b1;
            wr_addr  = init_cnt_reg;
            wr_depth = RESET_DEPTH;
            wr_color = '0;
        end
        else if (cmd.clr_wr)
        begin
            wr_en    = (rd_depth_reg < clear_depth_reg);
            wr_addr  = sweep_addr;
            wr_depth = clear_depth_reg;
            wr_color = clear_color_reg;
        end
        else if (cmd.finish)
        begin
            wr_en = draw_pass;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            depth_mem[wr_addr] <= wr_depth;
            color_mem[wr_addr] <= wr_color;
        end
        if (rd_en)
        begin
            rd_depth_reg <= depth_mem[rd_addr];
            rd_color_reg <= color_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            written_reg    <= draw_pass;
            read_color_reg <= '0;
            read_depth_reg <= '0;
            if (cmd_func_reg == FUNC_READ)
            begin
                read_color_reg <= cmd_in_frame_reg ? rd_color_reg : '0;
                read_depth_reg <= cmd_in_frame_reg ? rd_depth_reg : RESET_DEPTH;
            end
        end
    end

    always_comb
    begin
        status.in_func     = func_t'(func);
        status.clear_empty = (active_w == '0) || (active_h == '0);
        status.sweep_last  = cx_last && cy_last;
        status.init_last   = (init_cnt_reg == AW'(MEM_DEPTH - 1));
        status.out_free    = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign written    = written_reg;
    assign read_color = read_color_reg;
    assign read_depth = read_depth_reg;

endmodule

// ===== design/z_buffer_pixel_writer.sv =====
// Depth-buffered pixel store: top level joining sequencer and datapath.
//
// Input channel (in_valid/in_stall) carries one command per beat: func selects
// draw, clear or read; pos_x/pos_y/point_depth/point_color are the operands.
// Output channel (out_valid/out_stall) returns exactly one beat per command:
// written for draws, read_color/read_depth for reads, zeros otherwise.
// Config port (cfg_we/cfg_index/cfg_data) sets frame size and clear values;
// write only while no command is in flight.
// Sequencing: one command at a time. Draw and read go accept, store read, result
// load; the result load waits while the output register is stalled. Clear walks
// the active frame, a read then a conditional write per pixel on a single store
// port pair, and then loads its result beat.
// After reset the stores are swept to depth -100 / color 0, one entry per
// cycle over all MAX_WIDTH*MAX_HEIGHT entries (65536 at defaults), in_stall high.
// A stalled result holds in the output register; the next command is still
// accepted and waits for the register to drain before its result loads.
module z_buffer_pixel_writer
    import zbpw_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                func,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [DEPTH_W-1:0] point_depth,
    input  logic [COLOR_W-1:0]        point_color,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      written,
    output logic [COLOR_W-1:0]        read_color,
    output logic signed [DEPTH_W-1:0] read_depth
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    zbpw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    zbpw_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .point_depth (point_depth),
        .point_color (point_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .written     (written),
        .read_color  (read_color),
        .read_depth  (read_depth)
    );

endmodule

// ===== design/zbpw_checker.sv =====
// Port-level checks for the pixel writer, bound to the top level.
module zbpw_checker
    import zbpw_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      written,
    input logic [COLOR_W-1:0]        read_color,
    input logic signed [DEPTH_W-1:0] read_depth
);

    // stalled result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(written) && $stable(read_color)
                                   && $stable(read_depth))
        else $error("result payload changed while stalled");

    // one command in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second command taken while one is in flight");

    // a draw result never carries read data
    a_draw_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written |-> read_color == '0 && read_depth == '0)
        else $error("draw result carries read fields");

endmodule

bind z_buffer_pixel_writer zbpw_checker u_zbpw_checker (.*);
